// File: src/thumb_br_pkg.sv
package thumb_br_pkg;

  // branch forms carried by the opcode field
  localparam logic [2:0] OP_B_T1  = 3'd0;
  localparam logic [2:0] OP_B_T2  = 3'd1;
  localparam logic [2:0] OP_B_T3  = 3'd2;
  localparam logic [2:0] OP_BL_T1 = 3'd3;
  localparam logic [2:0] OP_BX_T1 = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_COND_E  = 2'd1;
  localparam logic [1:0] FAULT_IT_POS  = 2'd2;

  localparam logic [3:0] COND_AL       = 4'he;
  localparam logic [3:0] COND_NV       = 4'hf;

  typedef struct packed {
    logic        branch_taken;
    logic [31:0] target_pc;
    logic        link_write;
    logic [31:0] link_value;
    logic        thumb_bit;
    logic [1:0]  fault_code;
  } br_result_t;

  // standard condition test, 0xf passes like 0xe
  function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] nzcv);
    logic n;
    logic z;
    logic c;
    logic v;
    logic r;
    n = nzcv[3];
    z = nzcv[2];
    c = nzcv[1];
    v = nzcv[0];
    unique case (cond[3:1])
      3'd0:    r = z;
      3'd1:    r = c;
      3'd2:    r = n;
      3'd3:    r = v;
      3'd4:    r = c & ~z;
      3'd5:    r = (n == v);
      3'd6:    r = (n == v) & ~z;
      default: r = 1'b1;
    endcase
    if (cond[0] && (cond != COND_NV)) begin
      r = ~r;
    end
    return r;
  endfunction

endpackage

// File: src/thumb_branch_execute.sv
// Thumb branch execute unit. A request is taken on any clock edge where start is high and
// busy is low; busy never rises, so one branch can be issued every cycle. The request is
// captured in an input register, resolved by one pass of decode, condition test and a
// single 32-bit target adder, and the outcome is captured in a result register: done pulses
// for exactly one cycle once the request has passed the input and result registers, with the result ports valid in that
// cycle only. The receiver cannot stall the unit, so it must take each result as it appears.
// Faulting requests (reserved condition in B T1, bad IT-block position) give all-zero
// results except fault_code.
module thumb_branch_execute
  import thumb_br_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [31:0] instruction,
  input  logic [31:0] current_pc,
  input  logic [31:0] rm_value,
  input  logic [3:0]  flags_nzcv,
  input  logic        in_it_block,
  input  logic        last_in_it_block,
  output logic        done,
  output logic        branch_taken,
  output logic [31:0] target_pc,
  output logic        link_write,
  output logic [31:0] link_value,
  output logic        thumb_bit,
  output logic [1:0]  fault_code
);

  // input register
  logic        req_valid;
  logic [2:0]  op_q;
  logic [31:0] ins_q;
  logic [31:0] pc_q;
  logic [31:0] rm_q;
  logic [3:0]  nzcv_q;
  logic        it_q;
  logic        last_q;

  // result register
  logic        res_valid;
  br_result_t  res;
  br_result_t  res_next;

  // no back-pressure: a new request can be taken every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_q   <= opcode;
      ins_q  <= instruction;
      pc_q   <= current_pc;
      rm_q   <= rm_value;
      nzcv_q <= flags_nzcv;
      it_q   <= in_it_block;
      last_q <= last_in_it_block;
    end
  end

  // immediate fields shared by the 32-bit forms
  logic        s_bit;
  logic        j1;
  logic        j2;
  logic        i1;
  logic        i2;
  logic        not_last;
  logic [31:0] off_t1;
  logic [31:0] off_t2;
  logic [31:0] off_t3;
  logic [31:0] off_bl;
  logic [31:0] offset;
  logic [31:0] rel_target;
  logic        taken;
  logic        link;
  logic [31:0] target;
  logic        tbit;
  logic [1:0]  fault;

  assign s_bit    = ins_q[26];
  assign j1       = ins_q[13];
  assign j2       = ins_q[11];
  assign i1       = ~(j1 ^ s_bit);
  assign i2       = ~(j2 ^ s_bit);
  assign not_last = it_q & ~last_q;

  assign off_t1 = {{23{ins_q[7]}}, ins_q[7:0], 1'b0};
  assign off_t2 = {{20{ins_q[10]}}, ins_q[10:0], 1'b0};
  assign off_t3 = {{11{s_bit}}, s_bit, j2, j1, ins_q[21:16], ins_q[10:0], 1'b0};
  assign off_bl = {{7{s_bit}}, s_bit, i1, i2, ins_q[25:16], ins_q[10:0], 1'b0};

  // one adder serves every pc-relative form
  always_comb begin
    unique case (op_q)
      OP_B_T1:  offset = off_t1;
      OP_B_T2:  offset = off_t2;
      OP_B_T3:  offset = off_t3;
      OP_BL_T1: offset = off_bl;
      default:  offset = 32'd0;
    endcase
  end

  assign rel_target = pc_q + offset;

  always_comb begin
    taken  = 1'b0;
    link   = 1'b0;
    target = rel_target;
    tbit   = 1'b0;
    fault  = FAULT_NONE;
    unique case (op_q)
      OP_B_T1: begin
        // reserved condition is checked ahead of the it position
        if (ins_q[11:8] == COND_AL) begin
          fault = FAULT_COND_E;
        end else if (it_q) begin
          fault = FAULT_IT_POS;
        end else begin
          taken = cond_pass(ins_q[11:8], nzcv_q);
        end
      end
      OP_B_T2: begin
        if (not_last) begin
          fault = FAULT_IT_POS;
        end else begin
          taken = 1'b1;
        end
      end
      OP_B_T3: begin
        if (it_q) begin
          fault = FAULT_IT_POS;
        end else begin
          taken = cond_pass(ins_q[25:22], nzcv_q);
        end
      end
      OP_BL_T1: begin
        if (not_last) begin
          fault = FAULT_IT_POS;
        end else begin
          taken = 1'b1;
          link  = 1'b1;
        end
      end
      OP_BX_T1: begin
        if (not_last) begin
          fault = FAULT_IT_POS;
        end else begin
          taken  = 1'b1;
          target = rm_q;
          tbit   = rm_q[0];
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase

    // untaken or faulting branches give zeros apart from the fault code
    res_next.branch_taken = taken;
    res_next.target_pc    = taken ? {target[31:1], 1'b0} : 32'd0;
    res_next.link_write   = taken & link;
    res_next.link_value   = (taken && link) ? {pc_q[31:1], 1'b1} : 32'd0;
    res_next.thumb_bit    = taken & tbit;
    res_next.fault_code   = fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      res <= res_next;
    end
  end

  assign done         = res_valid;
  assign branch_taken = res.branch_taken;
  assign target_pc    = res.target_pc;
  assign link_write   = res.link_write;
  assign link_value   = res.link_value;
  assign thumb_bit    = res.thumb_bit;
  assign fault_code   = res.fault_code;

  // every request comes out on done after passing the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("request did not complete in two cycles");

  a_fault_suppress: assert property (@(posedge clk) disable iff (rst)
    done && (fault_code != FAULT_NONE) |-> !branch_taken && !link_write)
    else $error("faulting branch was taken");

  a_untaken_zero: assert property (@(posedge clk) disable iff (rst)
    done && !branch_taken |-> (target_pc == 32'd0) && (link_value == 32'd0) && !thumb_bit)
    else $error("untaken branch left non-zero result");

  a_link_form: assert property (@(posedge clk) disable iff (rst)
    done && link_write |-> branch_taken && link_value[0] && !target_pc[0])
    else $error("bad link result");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req_valid))
    else $error("result without a request");

endmodule
